// ----- design/cnv_pkg.sv -----
// ----------------------------------------------------------------------------
// cnv_pkg
// constants, types and helpers shared by the convolution block
// ----------------------------------------------------------------------------
package cnv_pkg;
    localparam int KERNEL_MAX     = 9;
    localparam int WIDTH_MAX      = 1024;
    localparam int PIXEL_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;

    localparam int KIDX_W  = $clog2(KERNEL_MAX);
    localparam int KSEL_W  = $clog2(KERNEL_MAX * KERNEL_MAX);
    localparam int COL_W   = $clog2(WIDTH_MAX);
    localparam int LADDR_W = $clog2(KERNEL_MAX * WIDTH_MAX);
    localparam int ENT_W   = PIXEL_BITS + 1;
    localparam int ACC_W   = 48;
    localparam int WSUM_W  = 24;
    localparam int QUO_W   = ACC_W;

    localparam logic [3:0] REG_WIDTH  = 4'd0;
    localparam logic [3:0] REG_HEIGHT = 4'd1;
    localparam logic [3:0] REG_KROWS  = 4'd2;
    localparam logic [3:0] REG_KCOLS  = 4'd3;
    localparam logic [3:0] REG_NAN    = 4'd4;

    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ADDR = 6'b000010,
        ST_MAC  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [ACC_W:0] v);
        logic [31:0] r;
        if (v > $signed({{(ACC_W - 30){1'b0}}, 31'h7FFFFFFF})) begin
            r = 32'h7FFFFFFF;
        end else if (v < $signed({{(ACC_W - 30){1'b1}}, 31'h0})) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction
endpackage

// ----- design/conv2d_valid_nan_normalized_top.sv -----
// ----------------------------------------------------------------------------
// conv2d_valid_nan_normalized_top
// streaming valid-border 2d convolution with optional missing-sample
// interpolation, one shared multiply-accumulate and a serial divider
// ----------------------------------------------------------------------------
//  channel  | ports                                  | direction
//  s_       | cmd, coef_*, pixel_value, pixel_invalid | in, valid/ready
//  m_       | out_value, out_row, out_col, used_*, .. | out, valid/ready
//  cfg      | cfg_wr_en, cfg_index, cfg_data          | in, write only
//
//  coefficient word, or pixel with no result: one word every cycle
//  pixel with result: no new word is accepted until its result word is
//  issued; nan mode with a nonzero weight sum adds 48 divide steps, and the
//  window taps are read one by one through the single line-memory read
//  port feeding one multiplier
//  reset is synchronous active low; kernel and line memories are not cleared
//  a result not yet taken holds the sequencer in its output step
// ----------------------------------------------------------------------------
module conv2d_valid_nan_normalized_top
    import cnv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [3:0]  s_coef_row,
    input  logic [3:0]  s_coef_col,
    input  logic signed [15:0] s_coef_value,
    input  logic signed [15:0] s_pixel_value,
    input  logic        s_pixel_invalid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_out_value,
    output logic [11:0] m_out_row,
    output logic [9:0]  m_out_col,
    output logic        m_used_center,
    output logic        m_frame_last
);
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [3:0]  krows_reg, kcols_reg;
    logic        nan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 11'd1024; height_reg <= 12'd512;
            krows_reg <= 4'd3; kcols_reg <= 4'd3; nan_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data;
                REG_KROWS:  krows_reg  <= cfg_data[3:0];
                REG_KCOLS:  kcols_reg  <= cfg_data[3:0];
                REG_NAN:    nan_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // memories
    logic signed [15:0] kmem [KERNEL_MAX*KERNEL_MAX];
    logic [ENT_W-1:0]   lmem [KERNEL_MAX*WIDTH_MAX];
    logic signed [15:0] k_rd;
    logic [ENT_W-1:0]   l_rd;
    logic [KSEL_W-1:0]  k_ra;
    logic [LADDR_W-1:0] l_ra;

    state_t state_reg;
    logic [11:0] row_reg, r_reg;
    logic [COL_W-1:0] col_reg, c_reg;
    logic [3:0] lslot_reg;           // r % KERNEL_MAX
    logic [11:0] w_eff, h_eff;
    logic [3:0] a_reg, b_reg;        // window index
    logic [3:0] slot_reg;
    logic       rd_v_reg, rd_ctr_reg;
    logic signed [ACC_W-1:0]  top_reg;
    logic signed [WSUM_W-1:0] bot_reg;
    logic [ENT_W-1:0] ctr_ent_reg;
    logic signed [31:0] prod_reg;
    logic prod_v_reg, prod_ok_reg;
    logic signed [15:0] kq_reg;
    logic [5:0] dcnt_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W:0]   rem_reg;
    logic [WSUM_W-1:0] dvs_reg;
    logic neg_reg;
    logic last_reg;

    assign w_eff = (width_reg == 11'd0) ? 12'd1 :
                   (width_reg > 11'(WIDTH_MAX)) ? 12'(WIDTH_MAX) : {1'b0, width_reg};
    assign h_eff = (height_reg == 12'd0) ? 12'd1 : height_reg;

    logic s_acc;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (s_acc && s_cmd == CMD_COEF && s_coef_row < 4'(KERNEL_MAX)
            && s_coef_col < 4'(KERNEL_MAX))
            kmem[KSEL_W'(s_coef_row * KERNEL_MAX + s_coef_col)] <= s_coef_value;
        k_rd <= kmem[k_ra];
        l_rd <= lmem[l_ra];
    end

    // position fix-up at accept
    logic [11:0] rn; logic [COL_W:0] cn; logic [3:0] sn;
    always_comb begin
        rn = row_reg; cn = {1'b0, col_reg}; sn = lslot_reg;
        if ({1'b0, cn} >= {1'b0, w_eff[COL_W:0]}) begin
            cn = '0; rn = rn + 12'd1;
            sn = (sn == 4'(KERNEL_MAX - 1)) ? 4'd0 : sn + 4'd1;
        end
        if (rn >= h_eff) begin rn = '0; sn = '0; end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_cmd == CMD_PIXEL)
            lmem[LADDR_W'(sn * WIDTH_MAX) + LADDR_W'(cn[COL_W-1:0])] <=
                {s_pixel_invalid, s_pixel_value};
    end

    logic emit;
    assign emit = krows_reg >= 4'd1 && krows_reg <= 4'(KERNEL_MAX) && krows_reg[0]
               && {8'd0, krows_reg} <= h_eff
               && kcols_reg >= 4'd1 && kcols_reg <= 4'(KERNEL_MAX) && kcols_reg[0]
               && {8'd0, kcols_reg} <= w_eff
               && rn + 12'd1 >= {8'd0, krows_reg}
               && {1'b0, cn} + 12'd1 >= {8'd0, kcols_reg};

    // read addresses for current window tap
    logic [COL_W:0] c0;
    assign c0 = {1'b0, c_reg} + 11'd1 - {7'd0, kcols_reg};
    assign l_ra = LADDR_W'(slot_reg * WIDTH_MAX) + LADDR_W'(c0 + {7'd0, b_reg});
    assign k_ra = KSEL_W'((krows_reg - 4'd1 - a_reg) * KERNEL_MAX
                          + (kcols_reg - 4'd1 - b_reg));

    logic signed [ACC_W:0] rnd;
    assign rnd = $signed({top_reg[ACC_W-1], top_reg})
               + $signed((ACC_W+1)'(1 << (COEF_FRAC_BITS - 1)));
    logic [QUO_W:0] rem_sh;
    assign rem_sh = {rem_reg[QUO_W-1:0], quo_reg[QUO_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; m_valid <= 1'b0;
            row_reg <= '0; col_reg <= '0; lslot_reg <= '0;
            rd_v_reg <= 1'b0; prod_v_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != ST_OUT) m_valid <= 1'b0;
            // product stage runs under every state
            rd_v_reg   <= (state_reg == ST_MAC);
            prod_v_reg <= rd_v_reg;
            prod_ok_reg <= !(nan_reg && l_rd[PIXEL_BITS]);
            prod_reg <= $signed(l_rd[PIXEL_BITS-1:0]) * k_rd;
            kq_reg <= k_rd;
            if (rd_v_reg && rd_ctr_reg) ctr_ent_reg <= l_rd;
            if (prod_v_reg && prod_ok_reg) begin
                top_reg <= top_reg + ACC_W'(prod_reg);
                bot_reg <= bot_reg + WSUM_W'(kq_reg);
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_cmd == CMD_PIXEL) begin
                        r_reg <= rn; c_reg <= cn[COL_W-1:0];
                        last_reg <= rn == h_eff - 12'd1
                                 && cn == w_eff[COL_W:0] - 11'd1;
                        // advance counters
                        if (cn + 11'd1 >= w_eff[COL_W:0]) begin
                            col_reg <= '0;
                            if (rn + 12'd1 >= h_eff) begin
                                row_reg <= '0; lslot_reg <= '0;
                            end else begin
                                row_reg <= rn + 12'd1;
                                lslot_reg <= (sn == 4'(KERNEL_MAX - 1)) ? 4'd0
                                                                        : sn + 4'd1;
                            end
                        end else begin
                            col_reg <= cn[COL_W-1:0] + COL_W'(1);
                            row_reg <= rn; lslot_reg <= sn;
                        end
                        if (emit) begin
                            // slot of first window row: sn - (kr-1) mod K
                            slot_reg <= (sn >= krows_reg - 4'd1) ? sn - (krows_reg - 4'd1)
                                      : sn + 4'(KERNEL_MAX) - (krows_reg - 4'd1);
                            state_reg <= ST_ADDR;
                        end
                    end
                end
                ST_ADDR: begin
                    a_reg <= '0; b_reg <= '0;
                    top_reg <= '0; bot_reg <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    rd_ctr_reg <= a_reg == (krows_reg >> 1) && b_reg == (kcols_reg >> 1);
                    if (b_reg == kcols_reg - 4'd1) begin
                        b_reg <= '0;
                        if (a_reg == krows_reg - 4'd1) begin
                            state_reg <= ST_DIV;
                            dcnt_reg <= '0;
                        end else begin
                            a_reg <= a_reg + 4'd1;
                            slot_reg <= (slot_reg == 4'(KERNEL_MAX - 1)) ? 4'd0
                                                                         : slot_reg + 4'd1;
                        end
                    end else begin
                        b_reg <= b_reg + 4'd1;
                    end
                end
                ST_DIV: begin
                    // wait for the two-stage tail, then set up the divide
                    if (dcnt_reg == 6'd3) begin
                        neg_reg <= top_reg[ACC_W-1] ^ bot_reg[WSUM_W-1];
                        quo_reg <= top_reg[ACC_W-1] ? QUO_W'(-top_reg) : QUO_W'(top_reg);
                        dvs_reg <= bot_reg[WSUM_W-1] ? WSUM_W'(-bot_reg) : WSUM_W'(bot_reg);
                        rem_reg <= '0;
                        dcnt_reg <= '0;
                        state_reg <= (nan_reg && bot_reg != '0) ? ST_FIN : ST_OUT;
                    end else begin
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                end
                ST_FIN: begin
                    // restoring divide, one bit per cycle
                    if (rem_sh >= {{(QUO_W+1-WSUM_W){1'b0}}, dvs_reg}) begin
                        rem_reg <= rem_sh - {{(QUO_W+1-WSUM_W){1'b0}}, dvs_reg};
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'(QUO_W - 1)) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // wait here while the previous result word is still held
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b1;
                        m_out_row <= r_reg - {8'd0, krows_reg >> 1};
                        m_out_col <= c_reg - COL_W'(kcols_reg >> 1);
                        m_frame_last <= last_reg;
                        m_used_center <= 1'b0;
                        if (!nan_reg) begin
                            m_out_value <= sat32(rnd >>> COEF_FRAC_BITS);
                        end else if (bot_reg == '0) begin
                            m_out_value <= 32'(signed'(ctr_ent_reg[PIXEL_BITS-1:0]));
                            m_used_center <= 1'b1;
                        end else begin
                            m_out_value <= neg_reg ? sat32(-$signed({1'b0, quo_reg}))
                                                   : sat32($signed({1'b0, quo_reg}));
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
